// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL of the page fault resolver.
// Each macro expects i_clk and a synchronous active-low i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: consequent must hold whenever the antecedent holds.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication: consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/core/dpfr_pkg.sv =====
// Package for the demand page fault resolver: sizes, codes, item and result types.
// Used by dpfr_ctrl and demand_page_fault_resolver; no dependencies.
package dpfr_pkg;

    localparam int MAX_SEGMENTS          = 8;
    localparam int MAX_PAGES_PER_SEGMENT = 1024;

    // segment table addressing and search counter
    localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);

    // page bitmap: rows of ROW_BITS page bits, each segment owns whole rows
    localparam int PG_W      = $clog2(MAX_PAGES_PER_SEGMENT);
    localparam int ROW_BITS  = 8;
    localparam int ROW_BW    = $clog2(ROW_BITS);
    localparam int ROWSEG_W  = PG_W - ROW_BW;
    localparam int ROW_AW    = SEG_AW + ROWSEG_W;
    localparam int ROW_DEPTH = 1 << ROW_AW;

    // field widths fixed by the interface
    localparam int ADDR_W = 32;
    localparam int PERM_W = 3;
    localparam int SLOT_W = 3;
    localparam int ZL_W   = 17;
    localparam int PS_W   = 5;
    localparam int SC_W   = 4;
    localparam int CFG_IW = 1;
    localparam int CFG_DW = 5;

    localparam logic [CFG_IW-1:0] REG_PAGE_SHIFT    = 1'b0;
    localparam logic [CFG_IW-1:0] REG_SEGMENT_COUNT = 1'b1;

    localparam logic [PS_W-1:0] PS_RESET  = 5'd12;
    localparam logic [PS_W-1:0] SHIFT_MIN = 5'd9;
    localparam logic [PS_W-1:0] SHIFT_MAX = 5'd16;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    typedef enum logic [2:0] {
        ACT_LOADED   = 3'd0,
        ACT_UNKNOWN  = 3'd1,
        ACT_MAPPED   = 3'd2,
        ACT_MAP      = 3'd3,
        ACT_CAPACITY = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SEG_RD,
        ST_SEG_CHK,
        ST_PAGE,
        ST_BIT,
        ST_ZERO,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] mem_len;
        logic [ADDR_W-1:0] file_len;
        logic [ADDR_W-1:0] file_offset;
        logic [PERM_W-1:0] perm;
    } t_seg;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] segment_slot;
        t_seg              seg;
        logic [ADDR_W-1:0] fault_address;
    } t_item;

    typedef struct packed {
        t_action           action;
        logic [ADDR_W-1:0] map_address;
        logic [ADDR_W-1:0] file_offset;
        logic [PERM_W-1:0] map_perm;
        logic [ADDR_W-1:0] zero_start;
        logic [ZL_W-1:0]   zero_length;
    } t_result;

    typedef struct packed {
        logic [PS_W-1:0] page_shift;
        logic [SC_W-1:0] segment_count;
    } t_cfg;

    function automatic t_result result_of(input t_action act);
        t_result res;
        res        = '0;
        res.action = act;
        return res;
    endfunction

endpackage

// ===== rtl/core/demand_page_fault_resolver.sv =====
// Resolve item: a segment read and a segment check per slot searched, then page index,
//   bitmap read, bitmap write and zero range, result; the output register then holds the result.
// Load item: table write, then a clear of the slot's 128 page bitmap rows
//   (one 8-bit row per cycle), then the result. One item is in flight at a time.
// Reset: page_shift 12, segment_count 0; the 1024-row page bitmap is swept to zero
//   after reset, with input stalled. Config writes are taken always.
module demand_page_fault_resolver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [2:0]  i_segment_slot,
    input  logic [31:0] i_seg_base,
    input  logic [31:0] i_seg_mem_size,
    input  logic [31:0] i_seg_file_size,
    input  logic [31:0] i_seg_file_offset,
    input  logic [2:0]  i_seg_perm,
    input  logic [31:0] i_fault_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_action,
    output logic [31:0] o_map_address,
    output logic [31:0] o_file_offset,
    output logic [2:0]  o_map_perm,
    output logic [31:0] o_zero_start,
    output logic [16:0] o_zero_length,
    input  logic        i_cfg_we,
    input  logic [dpfr_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [dpfr_pkg::CFG_DW-1:0] i_cfg_data
);
    import dpfr_pkg::*;

    t_cfg                r_cfg;
    t_item               w_item;
    logic                r_out_valid;
    t_result             r_out;
    logic                w_take;
    logic                w_res_valid;
    t_result             w_res;

    logic                w_seg_we;
    logic [SEG_AW-1:0]   w_seg_waddr;
    t_seg                w_seg_wdata;
    logic [SEG_AW-1:0]   w_seg_raddr;
    t_seg                w_seg_rdata;
    logic                w_bm_we;
    logic [ROW_AW-1:0]   w_bm_waddr;
    logic [ROW_BITS-1:0] w_bm_wdata;
    logic [ROW_AW-1:0]   w_bm_raddr;
    logic [ROW_BITS-1:0] w_bm_rdata;

    always_comb begin
        w_item.operation       = i_operation;
        w_item.segment_slot    = i_segment_slot;
        w_item.seg.base        = i_seg_base;
        w_item.seg.mem_len     = i_seg_mem_size;
        w_item.seg.file_len    = i_seg_file_size;
        w_item.seg.file_offset = i_seg_file_offset;
        w_item.seg.perm        = i_seg_perm;
        w_item.fault_address   = i_fault_address;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.page_shift    <= PS_RESET;
            r_cfg.segment_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PAGE_SHIFT:    r_cfg.page_shift    <= i_cfg_data[PS_W-1:0];
                REG_SEGMENT_COUNT: r_cfg.segment_count <= i_cfg_data[SC_W-1:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    dpfr_ram #(
        .WIDTH ($bits(t_seg)),
        .DEPTH (1 << SEG_AW)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (w_seg_we),
        .i_waddr (w_seg_waddr),
        .i_wdata (w_seg_wdata),
        .i_raddr (w_seg_raddr),
        .o_rdata (w_seg_rdata)
    );

    dpfr_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROW_DEPTH)
    ) u_bitmap_ram (
        .i_clk   (i_clk),
        .i_we    (w_bm_we),
        .i_waddr (w_bm_waddr),
        .i_wdata (w_bm_wdata),
        .i_raddr (w_bm_raddr),
        .o_rdata (w_bm_rdata)
    );

    dpfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_item      (w_item),
        .o_seg_we    (w_seg_we),
        .o_seg_waddr (w_seg_waddr),
        .o_seg_wdata (w_seg_wdata),
        .o_seg_raddr (w_seg_raddr),
        .i_seg_rdata (w_seg_rdata),
        .o_bm_we     (w_bm_we),
        .o_bm_waddr  (w_bm_waddr),
        .o_bm_wdata  (w_bm_wdata),
        .o_bm_raddr  (w_bm_raddr),
        .i_bm_rdata  (w_bm_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_take)
    );

    // output register frees up when empty or when its transfer completes
    assign w_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_out.action;
    assign o_map_address = r_out.map_address;
    assign o_file_offset = r_out.file_offset;
    assign o_map_perm    = r_out.map_perm;
    assign o_zero_start  = r_out.zero_start;
    assign o_zero_length = r_out.zero_length;

endmodule

// ===== rtl/core/dpfr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module dpfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dpfr_ctrl.sv =====
// Sequencer of the page fault resolver: segment search, page bitmap read-modify-write,
// zero-fill range. Depends on dpfr_pkg and assert_macros.svh; drives two dpfr_ram instances.
`include "assert_macros.svh"

module dpfr_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dpfr_pkg::t_cfg                  i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  dpfr_pkg::t_item                 i_item,
    output logic                            o_seg_we,
    output logic [dpfr_pkg::SEG_AW-1:0]     o_seg_waddr,
    output dpfr_pkg::t_seg                  o_seg_wdata,
    output logic [dpfr_pkg::SEG_AW-1:0]     o_seg_raddr,
    input  dpfr_pkg::t_seg                  i_seg_rdata,
    output logic                            o_bm_we,
    output logic [dpfr_pkg::ROW_AW-1:0]     o_bm_waddr,
    output logic [dpfr_pkg::ROW_BITS-1:0]   o_bm_wdata,
    output logic [dpfr_pkg::ROW_AW-1:0]     o_bm_raddr,
    input  logic [dpfr_pkg::ROW_BITS-1:0]   i_bm_rdata,
    output logic                            o_res_valid,
    output dpfr_pkg::t_result               o_res,
    input  logic                            i_res_take
);
    import dpfr_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [ROW_AW-1:0]   r_row;
    logic [SEG_CW-1:0]   r_idx;
    logic [ADDR_W-1:0]   r_addr;
    t_seg                r_seg;
    logic [ADDR_W-1:0]   r_off;
    logic [SEG_AW-1:0]   r_hit;
    logic [PG_W-1:0]     r_pidx;
    logic [ADDR_W-1:0]   r_fp;
    logic [ADDR_W-1:0]   r_zs;
    logic [ADDR_W-1:0]   r_ze;
    t_result             r_res;

    logic                w_accept;
    logic                w_slot_ok;
    logic [SEG_CW-1:0]   w_cnt;
    logic [SEG_CW-1:0]   w_idx_nx;
    logic [PS_W-1:0]     w_sh;
    logic [ADDR_W:0]     w_diff;
    logic                w_contain;
    logic [ADDR_W-1:0]   w_pidx_full;
    logic                w_over;
    logic [PG_W-1:0]     w_pidx;
    logic [ADDR_W:0]     w_psz;
    logic [ADDR_W-1:0]   w_fp;
    logic [ROW_AW-1:0]   w_page_row;
    logic [ROW_AW-1:0]   w_hit_row;
    logic                w_bit;
    logic [ADDR_W:0]     w_pend;
    logic [ADDR_W-1:0]   w_zs;
    logic [ADDR_W-1:0]   w_ze;
    t_result             w_map_res;
    logic                w_res_is_map;
    logic                w_res_tail_zero;

    assign w_accept  = i_in_valid && (r_state == ST_IDLE);
    assign w_slot_ok = 32'(i_item.segment_slot) < MAX_SEGMENTS;
    assign w_cnt     = (32'(i_cfg.segment_count) > MAX_SEGMENTS) ? SEG_CW'(MAX_SEGMENTS)
                                                                  : SEG_CW'(i_cfg.segment_count);
    assign w_idx_nx  = r_idx + SEG_CW'(1);

    always_comb begin
        if (i_cfg.page_shift < SHIFT_MIN) begin
            w_sh = SHIFT_MIN;
        end else if (i_cfg.page_shift > SHIFT_MAX) begin
            w_sh = SHIFT_MAX;
        end else begin
            w_sh = i_cfg.page_shift;
        end
    end

    // containment against the exact 33-bit segment end
    assign w_diff    = {1'b0, r_addr} - {1'b0, i_seg_rdata.base};
    assign w_contain = !w_diff[ADDR_W] && (w_diff[ADDR_W-1:0] < i_seg_rdata.mem_len);

    assign w_psz       = (ADDR_W+1)'(1) << w_sh;
    assign w_pidx_full = r_off >> w_sh;
    assign w_over      = w_pidx_full >= 32'(MAX_PAGES_PER_SEGMENT);
    assign w_pidx      = w_pidx_full[PG_W-1:0];
    assign w_fp        = r_off & ~(w_psz[ADDR_W-1:0] - 32'd1);
    assign w_page_row  = {r_hit, w_pidx[PG_W-1:ROW_BW]};
    assign w_hit_row   = {r_hit, r_pidx[PG_W-1:ROW_BW]};

    assign w_bit  = i_bm_rdata[r_pidx[ROW_BW-1:0]];
    assign w_pend = {1'b0, r_fp} + w_psz;
    assign w_ze   = (w_pend < {1'b0, r_seg.mem_len}) ? w_pend[ADDR_W-1:0] : r_seg.mem_len;
    assign w_zs   = (r_fp > r_seg.file_len) ? r_fp : r_seg.file_len;

    always_comb begin
        w_map_res             = result_of(ACT_MAP);
        w_map_res.map_address = r_seg.base + r_fp;
        w_map_res.file_offset = r_seg.file_offset + r_fp;
        w_map_res.map_perm    = r_seg.perm;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (&r_row) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_item.operation == OP_LOAD) begin
                        n_state = w_slot_ok ? ST_CLEAR : ST_EMIT;
                    end else begin
                        n_state = (w_cnt == '0) ? ST_EMIT : ST_SEG_RD;
                    end
                end
            end
            ST_CLEAR: begin
                if (&r_row[ROWSEG_W-1:0]) begin
                    n_state = ST_EMIT;
                end
            end
            ST_SEG_RD: begin
                n_state = ST_SEG_CHK;
            end
            ST_SEG_CHK: begin
                if (w_contain) begin
                    n_state = ST_PAGE;
                end else if (w_idx_nx >= w_cnt) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SEG_RD;
                end
            end
            ST_PAGE: begin
                n_state = w_over ? ST_EMIT : ST_BIT;
            end
            ST_BIT: begin
                n_state = w_bit ? ST_EMIT : ST_ZERO;
            end
            ST_ZERO: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_seg_we    = w_accept && (i_item.operation == OP_LOAD) && w_slot_ok;
        o_seg_waddr = SEG_AW'(i_item.segment_slot);
        o_seg_wdata = i_item.seg;
        o_seg_raddr = r_idx[SEG_AW-1:0];
        o_bm_raddr  = w_page_row;
        o_bm_we     = 1'b0;
        o_bm_waddr  = r_row;
        o_bm_wdata  = '0;
        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                o_bm_we = 1'b1;
            end
            ST_BIT: begin
                // set the page bit, keep its neighbors in the row
                o_bm_we    = !w_bit;
                o_bm_waddr = w_hit_row;
                o_bm_wdata = i_bm_rdata | (ROW_BITS'(1) << r_pidx[ROW_BW-1:0]);
            end
            default: begin
                o_bm_we = 1'b0;
            end
        endcase
        o_res_valid = (r_state == ST_EMIT);
        o_res       = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_row   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state) inside
                ST_INIT, ST_CLEAR: begin
                    r_row <= r_row + ROW_AW'(1);
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_row <= {SEG_AW'(i_item.segment_slot), ROWSEG_W'(0)};
                        r_idx <= '0;
                    end
                end
                ST_SEG_CHK: begin
                    r_idx <= w_idx_nx;
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_addr <= i_item.fault_address;
                    // preset the answer a failed search or a load gives
                    r_res  <= (i_item.operation == OP_LOAD) ? result_of(ACT_LOADED)
                                                             : result_of(ACT_UNKNOWN);
                end
            end
            ST_SEG_CHK: begin
                r_seg <= i_seg_rdata;
                r_off <= w_diff[ADDR_W-1:0];
                r_hit <= r_idx[SEG_AW-1:0];
            end
            ST_PAGE: begin
                r_pidx <= w_pidx;
                r_fp   <= w_fp;
                if (w_over) begin
                    r_res <= result_of(ACT_CAPACITY);
                end
            end
            ST_BIT: begin
                r_zs  <= w_zs;
                r_ze  <= w_ze;
                r_res <= w_bit ? result_of(ACT_MAPPED) : w_map_res;
            end
            ST_ZERO: begin
                if (r_ze > r_zs) begin
                    r_res.zero_start  <= r_seg.base + r_zs;
                    r_res.zero_length <= ZL_W'(r_ze - r_zs);
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    // result fields that only a map order may carry
    assign w_res_is_map    = (o_res.action == ACT_MAP);
    assign w_res_tail_zero = (o_res.map_address == '0) && (o_res.file_offset == '0) &&
                             (o_res.map_perm == '0) && (o_res.zero_start == '0) &&
                             (o_res.zero_length == '0);

    `ASSERT_NEXT(a_accept_leaves_idle, w_accept, r_state != ST_IDLE)
    `ASSERT_IMPL(a_rmw_same_row, (r_state == ST_BIT) && o_bm_we, o_bm_waddr == $past(o_bm_raddr))
    `ASSERT_IMPL(a_hit_in_range, r_state == ST_PAGE, 32'(r_hit) < 32'(w_cnt))
    `ASSERT_IMPL(a_zero_fits_page, o_res_valid && w_res_is_map, 33'(o_res.zero_length) <= w_psz)
    `ASSERT_IMPL(a_plain_answer_zero, o_res_valid && !w_res_is_map, w_res_tail_zero)

endmodule
